[src/bcrd_pkg.sv]
// bcrd_pkg: shared types and constants for the keypad click and auto-repeat detector
// no dependencies; imported by every module of the block

package bcrd_pkg;

    localparam int NUM_KEYS = 6;
    localparam int COUNT_W  = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_AW   = 3;

    typedef logic [2:0] t_key;
    typedef logic [2:0] t_kind;
    typedef logic [1:0] t_act;

    // virtual keys
    localparam t_key KEY_POWER   = 3'd0;
    localparam t_key KEY_UP      = 3'd1;
    localparam t_key KEY_DOWN    = 3'd2;
    localparam t_key KEY_UPDOWN  = 3'd3;
    localparam t_key KEY_PWRUP   = 3'd4;
    localparam t_key KEY_PWRDOWN = 3'd5;
    localparam t_key OWNER_NONE  = 3'd7;

    // event kinds
    localparam t_kind KIND_CLICK  = 3'd0;
    localparam t_kind KIND_LONG   = 3'd1;
    localparam t_kind KIND_SLOW   = 3'd2;
    localparam t_kind KIND_MEDIUM = 3'd3;
    localparam t_kind KIND_FAST   = 3'd4;

    // per-key action for one tick
    localparam t_act ACT_RESET = 2'd0;
    localparam t_act ACT_DOWN  = 2'd1;
    localparam t_act ACT_UP    = 2'd2;

    // register indexes
    localparam logic [CFG_AW-1:0] CFG_SWAP       = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_TICK       = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_LONG       = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_SLOW       = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_MEDIUM     = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_FAST       = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_MED_AFTER  = 3'd6;
    localparam logic [CFG_AW-1:0] CFG_FAST_AFTER = 3'd7;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // order in which key events are offered to the owner logic
    localparam t_key KEY_ORDER [NUM_KEYS] = '{
        KEY_POWER, KEY_UPDOWN, KEY_UP, KEY_DOWN, KEY_PWRUP, KEY_PWRDOWN
    };

    typedef struct packed {
        logic [7:0]         tick_ms;
        logic [15:0]        long_ms;
        logic [15:0]        slow_ms;
        logic [15:0]        medium_ms;
        logic [15:0]        fast_ms;
        logic [COUNT_W-1:0] medium_after;
        logic [COUNT_W-1:0] fast_after;
    } t_timing;

    typedef struct packed {
        logic  req;
        t_kind kind;
    } t_fire;

    typedef struct packed {
        logic  have;
        t_key  key;
        t_kind kind;
    } t_result;

endpackage

[src/bcrd_key_slot.sv]
// bcrd_key_slot: hold timer, event count and held flag of one virtual key
// depends on bcrd_pkg

module bcrd_key_slot #(
    parameter int TIMER_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  bcrd_pkg::t_act  i_act,
    input  bcrd_pkg::t_timing i_tim,
    output bcrd_pkg::t_fire o_fire,
    output logic            o_held
);
    import bcrd_pkg::*;

    localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    logic [TIMER_BITS-1:0] r_timer, n_timer;
    logic [COUNT_W-1:0]    r_count, n_count;
    logic                  r_held, n_held;

    logic [TIMER_BITS:0]   w_sum;
    logic [TIMER_BITS-1:0] w_sat;
    logic [15:0]           w_limit;
    t_kind                 w_kind;
    logic                  w_hit;

    // saturating timer add
    assign w_sum = {1'b0, r_timer} + {{(TIMER_BITS + 1 - 8){1'b0}}, i_tim.tick_ms};
    assign w_sat = w_sum[TIMER_BITS] ? {TIMER_BITS{1'b1}} : w_sum[TIMER_BITS-1:0];

    always_comb begin
        if (r_count == '0) begin
            w_kind  = KIND_LONG;
            w_limit = i_tim.long_ms;
        end else if (r_count > i_tim.fast_after) begin
            w_kind  = KIND_FAST;
            w_limit = i_tim.fast_ms;
        end else if (r_count > i_tim.medium_after) begin
            w_kind  = KIND_MEDIUM;
            w_limit = i_tim.medium_ms;
        end else begin
            w_kind  = KIND_SLOW;
            w_limit = i_tim.slow_ms;
        end
    end

    assign w_hit = CMP_W'(w_sat) >= CMP_W'(w_limit);

    always_comb begin
        n_timer     = r_timer;
        n_count     = r_count;
        n_held      = r_held;
        o_fire.req  = 1'b0;
        o_fire.kind = w_kind;
        case (i_act)
            ACT_DOWN: begin
                if (!r_held) begin
                    n_held = 1'b1;
                end else if (w_hit) begin
                    o_fire.req = 1'b1;
                    n_timer    = '0;
                    n_count    = (r_count == COUNT_MAX) ? r_count : r_count + 16'd1;
                end else begin
                    n_timer = w_sat;
                end
            end
            ACT_UP: begin
                // release of a key that never fired gives a click
                o_fire.req  = r_held && (r_count == '0);
                o_fire.kind = KIND_CLICK;
                n_timer     = '0;
                n_count     = '0;
                n_held      = 1'b0;
            end
            default: begin
                n_timer = '0;
                n_count = '0;
                n_held  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer <= '0;
            r_count <= '0;
            r_held  <= 1'b0;
        end else if (i_en) begin
            r_timer <= n_timer;
            r_count <= n_count;
            r_held  <= n_held;
        end
    end

    assign o_held = r_held;

endmodule

[src/bcrd_owner_arb.sv]
// bcrd_owner_arb: ownership filter and result pick over the key events of one tick
// depends on bcrd_pkg

module bcrd_owner_arb (
    input  bcrd_pkg::t_fire   i_fire [bcrd_pkg::NUM_KEYS],
    input  bcrd_pkg::t_key    i_owner,
    input  logic              i_release_all,
    output bcrd_pkg::t_result o_res,
    output bcrd_pkg::t_key    o_owner
);
    import bcrd_pkg::*;

    t_key  w_k;
    t_key  w_owner;

    always_comb begin
        w_owner    = i_owner;
        w_k        = KEY_POWER;
        o_res.have = 1'b0;
        o_res.key  = KEY_POWER;
        o_res.kind = KIND_CLICK;
        for (int i = 0; i < NUM_KEYS; i++) begin
            w_k = KEY_ORDER[i];
            if (i_fire[w_k].req && (w_owner == OWNER_NONE || w_owner == w_k)) begin
                w_owner = w_k;
                // combination keys only report their long click
                if (!(w_k >= KEY_UPDOWN && i_fire[w_k].kind != KIND_LONG) && !o_res.have) begin
                    o_res.have = 1'b1;
                    o_res.key  = w_k;
                    o_res.kind = i_fire[w_k].kind;
                end
            end
        end
        if (i_release_all) begin
            w_owner = OWNER_NONE;
        end
        o_owner = w_owner;
    end

endmodule

[src/button_click_repeat_detector.sv]
// button_click_repeat_detector: top level of the keypad click, long press and auto-repeat detector
// depends on bcrd_pkg, bcrd_key_slot and bcrd_owner_arb
//
// channel    direction  word layout (lsb first)                      accepted when
// s_axis     in         power, mode, up, down levels, 4 zero bits     tvalid && tready
// m_axis     out        event_key[2:0], event_kind[2:0], 2 zero bits  tvalid && tready
// cfg        in         index i_cfg_addr, data i_cfg_wdata            i_cfg_we
//
// one word per cycle sustained while the output is not stalled; a word passes through the
// input register and its event, if any, is registered in the output register
// the six key slots and the owner logic update together as the word leaves the input register
// reset is synchronous: timers, counts and held flags clear, owner becomes none,
// configuration registers take their defaults
// a stalled output holds the input register; input ready drops only while both
// registers are full and the output is not being taken

module button_click_repeat_detector #(
    parameter int TIMER_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [7:0]                    i_s_axis_tdata,  // power, mode, up, down levels
    // output stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [7:0]                    o_m_axis_tdata,  // event_key[2:0], event_kind[5:3]
    // register writes
    input  logic                          i_cfg_we,
    input  logic [bcrd_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [bcrd_pkg::CFG_W-1:0]    i_cfg_wdata
);
    import bcrd_pkg::*;

    // configuration registers
    logic    r_swap;
    t_timing r_tim;

    // input register
    logic       r_in_valid;
    logic [3:0] r_lvl;

    // owner and output register
    t_key       r_owner;
    logic       r_out_valid;
    t_key       r_out_key;
    t_kind      r_out_kind;

    logic       w_proc;
    logic       w_accept;
    logic       w_pwr, w_up_raw, w_dn_raw, w_up, w_dn;
    logic       w_release_all;
    t_act       w_act  [NUM_KEYS];
    t_fire      w_fire [NUM_KEYS];
    logic [NUM_KEYS-1:0] w_held;
    t_result    w_res;
    t_key       w_owner_next;

    // a buffered word moves on when the output slot is free or being emptied
    assign w_proc          = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_proc;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap          <= 1'b0;
            r_tim.tick_ms   <= 8'd10;
            r_tim.long_ms   <= 16'd500;
            r_tim.slow_ms   <= 16'd200;
            r_tim.medium_ms <= 16'd100;
            r_tim.fast_ms   <= 16'd50;
            r_tim.medium_after <= 16'd20;
            r_tim.fast_after   <= 16'd90;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SWAP:       r_swap             <= i_cfg_wdata[0];
                CFG_TICK:       r_tim.tick_ms      <= i_cfg_wdata[7:0];
                CFG_LONG:       r_tim.long_ms      <= i_cfg_wdata;
                CFG_SLOW:       r_tim.slow_ms      <= i_cfg_wdata;
                CFG_MEDIUM:     r_tim.medium_ms    <= i_cfg_wdata;
                CFG_FAST:       r_tim.fast_ms      <= i_cfg_wdata;
                CFG_MED_AFTER:  r_tim.medium_after <= i_cfg_wdata;
                CFG_FAST_AFTER: r_tim.fast_after   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_lvl <= i_s_axis_tdata[3:0];
        end
    end

    // levels are active low; mode acts as a second power key
    assign w_pwr    = !r_lvl[0] || !r_lvl[1];
    assign w_up_raw = !r_lvl[2];
    assign w_dn_raw = !r_lvl[3];
    assign w_up     = r_swap ? w_dn_raw : w_up_raw;
    assign w_dn     = r_swap ? w_up_raw : w_dn_raw;
    assign w_release_all = !w_pwr && !w_up && !w_dn;

    // resolve the pressed keys into one action per virtual key
    always_comb begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            w_act[k] = ACT_RESET;
        end
        if (w_pwr) begin
            if (w_up) begin
                w_act[KEY_PWRUP] = ACT_DOWN;
            end else if (w_dn) begin
                w_act[KEY_PWRDOWN] = ACT_DOWN;
            end else begin
                w_act[KEY_POWER] = ACT_DOWN;
            end
        end else begin
            w_act[KEY_POWER] = ACT_UP;
            if (w_up && w_dn) begin
                w_act[KEY_UPDOWN] = ACT_DOWN;
            end else if (w_up) begin
                w_act[KEY_UP] = ACT_DOWN;
            end else begin
                w_act[KEY_UP]   = ACT_UP;
                w_act[KEY_DOWN] = w_dn ? ACT_DOWN : ACT_UP;
            end
        end
    end

    for (genvar g = 0; g < NUM_KEYS; g++) begin : g_slot
        bcrd_key_slot #(
            .TIMER_BITS (TIMER_BITS)
        ) u_slot (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_proc),
            .i_act   (w_act[g]),
            .i_tim   (r_tim),
            .o_fire  (w_fire[g]),
            .o_held  (w_held[g])
        );
    end

    bcrd_owner_arb u_arb (
        .i_fire        (w_fire),
        .i_owner       (r_owner),
        .i_release_all (w_release_all),
        .o_res         (w_res),
        .o_owner       (w_owner_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner     <= OWNER_NONE;
            r_out_valid <= 1'b0;
        end else if (w_proc) begin
            r_owner     <= w_owner_next;
            r_out_valid <= w_res.have;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && w_res.have) begin
            r_out_key  <= w_res.key;
            r_out_kind <= w_res.kind;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_kind, r_out_key};

    // every tick leaves at most one virtual key held
    a_one_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_held))
        else $error("more than one key held");

    // combination keys report only the long click
    a_combo_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[2:0] >= KEY_UPDOWN)
            |-> o_m_axis_tdata[5:3] == KIND_LONG)
        else $error("combination key reported other than long click");

    // a full release frees the owner
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && w_release_all) |=> r_owner == OWNER_NONE)
        else $error("owner kept after full release");

    // a reported event belongs to the owner
    a_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && w_res.have && !w_release_all) |=> r_owner == r_out_key)
        else $error("reported key is not the owner");

    // output codes stay in range
    a_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[2:0] <= KEY_PWRDOWN
            && o_m_axis_tdata[5:3] <= KIND_FAST))
        else $error("event code out of range");

endmodule

[verif/button_click_repeat_detector_tb.sv]
// button_click_repeat_detector_tb: self-checking bench for the keypad click and auto-repeat detector
// drives key level words and register writes, predicts every event and compares it word by word
// depends on bcrd_pkg and button_click_repeat_detector

`timescale 1ns / 100ps

module button_click_repeat_detector_tb;

    import bcrd_pkg::*;

    localparam int TIMER_BITS   = 16;
    localparam int NUM_REGS     = 8;
    localparam int DRAIN_CYCLES = 6;          // input register, output register and margin
    localparam int CYCLE_LIMIT  = 1_000_000;

    // key level words, bit 0 power, 1 mode, 2 up, 3 down, low means pressed
    localparam logic [3:0] LV_NONE    = 4'hF;
    localparam logic [3:0] LV_POWER   = 4'hE;
    localparam logic [3:0] LV_MODE    = 4'hD;
    localparam logic [3:0] LV_UP      = 4'hB;
    localparam logic [3:0] LV_DOWN    = 4'h7;
    localparam logic [3:0] LV_UPDOWN  = 4'h3;
    localparam logic [3:0] LV_PWRUP   = 4'hA;
    localparam logic [3:0] LV_PWRDOWN = 4'h6;
    localparam logic [3:0] LV_MODEDN  = 4'h5;
    localparam logic [3:0] LV_ALL     = 4'h0;

    typedef enum {PH_TYPICAL, PH_WIDE, PH_MAX, PH_ZERO, PH_TSAT} t_phase;

    typedef struct packed {
        t_key  key;
        t_kind kind;
    } t_event;

    // one directed row: a level word held for reps ticks; where typed is set, the
    // last tick's outcome is the hit/key/kind given here instead of the prediction
    typedef struct packed {
        logic [3:0] lv;
        logic [9:0] reps;
        logic       typed;
        logic       hit;
        t_key       key;
        t_kind      kind;
    } t_row;

    // directed run at the reset timing: tick 10 ms, long press 500 ms, slow 200 ms
    localparam t_row SCRIPT [25] = '{
        '{LV_NONE,    10'd2,   1'b1, 1'b0, KEY_POWER,   KIND_CLICK},
        '{LV_POWER,   10'd1,   1'b0, 1'b0, KEY_POWER,   KIND_CLICK},
        '{LV_NONE,    10'd1,   1'b1, 1'b1, KEY_POWER,   KIND_CLICK},
        '{LV_MODE,    10'd1,   1'b0, 1'b0, KEY_POWER,   KIND_CLICK},
        '{LV_NONE,    10'd1,   1'b1, 1'b1, KEY_POWER,   KIND_CLICK},
        '{LV_UP,      10'd50,  1'b1, 1'b0, KEY_POWER,   KIND_CLICK},
        '{LV_UP,      10'd1,   1'b1, 1'b1, KEY_UP,      KIND_LONG},
        '{LV_UP,      10'd20,  1'b1, 1'b1, KEY_UP,      KIND_SLOW},
        '{LV_UP,      10'd10,  1'b0, 1'b0, KEY_POWER,   KIND_CLICK},
        '{LV_NONE,    10'd1,   1'b1, 1'b0, KEY_POWER,   KIND_CLICK},
        '{LV_DOWN,    10'd51,  1'b1, 1'b1, KEY_DOWN,    KIND_LONG},
        '{LV_UPDOWN,  10'd60,  1'b1, 1'b0, KEY_POWER,   KIND_CLICK},
        '{LV_NONE,    10'd1,   1'b0, 1'b0, KEY_POWER,   KIND_CLICK},
        '{LV_UPDOWN,  10'd51,  1'b1, 1'b1, KEY_UPDOWN,  KIND_LONG},
        '{LV_UPDOWN,  10'd25,  1'b1, 1'b0, KEY_POWER,   KIND_CLICK},
        '{LV_NONE,    10'd1,   1'b0, 1'b0, KEY_POWER,   KIND_CLICK},
        '{LV_PWRUP,   10'd51,  1'b1, 1'b1, KEY_PWRUP,   KIND_LONG},
        '{LV_PWRDOWN, 10'd51,  1'b1, 1'b0, KEY_POWER,   KIND_CLICK},
        '{LV_NONE,    10'd1,   1'b0, 1'b0, KEY_POWER,   KIND_CLICK},
        '{LV_PWRDOWN, 10'd51,  1'b1, 1'b1, KEY_PWRDOWN, KIND_LONG},
        '{LV_NONE,    10'd1,   1'b0, 1'b0, KEY_POWER,   KIND_CLICK},
        '{LV_MODEDN,  10'd1,   1'b0, 1'b0, KEY_POWER,   KIND_CLICK},
        '{LV_NONE,    10'd1,   1'b1, 1'b0, KEY_POWER,   KIND_CLICK},
        '{LV_ALL,     10'd1,   1'b0, 1'b0, KEY_POWER,   KIND_CLICK},
        '{LV_NONE,    10'd1,   1'b0, 1'b0, KEY_POWER,   KIND_CLICK}
    };

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    logic [7:0]          s_data    = 8'h0F;   // power, mode, up, down levels, 4 zero bits
    logic                m_valid;
    logic                m_ready   = 1'b0;
    logic [7:0]          m_data;              // event_key[2:0], event_kind[5:3], 2 zero bits
    logic                cfg_we    = 1'b0;
    logic [CFG_AW-1:0]   cfg_addr  = '0;
    logic [CFG_W-1:0]    cfg_wdata = '0;

    // bench-side copy of the block: registers, per-key timers, counts, held flags, owner
    logic [15:0]           timing_regs [NUM_REGS];
    logic [15:0]           next_regs   [NUM_REGS];
    logic [TIMER_BITS-1:0] hold_tmr    [NUM_KEYS];
    logic [COUNT_W-1:0]    ev_cnt      [NUM_KEYS];
    logic                  held        [NUM_KEYS];
    t_key                  owner;
    logic                  tick_hit;
    t_event                tick_ev;

    t_event events_due [$];   // predicted events not yet seen on the output
    int     fail_count  = 0;
    int     words_sent  = 0;
    int     cycle_count = 0;
    int     stall_left  = 0;
    bit     idle_on     = 1'b1;

    button_click_repeat_detector #(
        .TIMER_BITS (TIMER_BITS)
    ) i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // event predictor
    // ------------------------------------------------------------------

    function automatic void drop_key(input int k);
        hold_tmr[k] = '0;
        ev_cnt[k]   = '0;
        held[k]     = 1'b0;
    endfunction

    // an event claims the owner slot; combination keys only report their long click,
    // and only the first event of a tick can reach the output
    function automatic void claim(input int k, input t_kind kind);
        if (owner != OWNER_NONE && owner != t_key'(k))
            return;
        owner = t_key'(k);
        if (k >= int'(KEY_UPDOWN) && kind != KIND_LONG)
            return;
        if (!tick_hit) begin
            tick_hit     = 1'b1;
            tick_ev.key  = t_key'(k);
            tick_ev.kind = kind;
        end
    endfunction

    function automatic void press_tick(input int k);
        logic [TIMER_BITS:0] sum;
        logic [15:0]         limit;
        t_kind               kind;
        // first tick only marks the key as held
        if (!held[k]) begin
            held[k] = 1'b1;
            return;
        end
        sum = {1'b0, hold_tmr[k]} + {{(TIMER_BITS + 1 - 8){1'b0}}, timing_regs[CFG_TICK][7:0]};
        hold_tmr[k] = sum[TIMER_BITS] ? '1 : sum[TIMER_BITS-1:0];
        // the count picks the interval: long press first, then slow, medium, fast
        if (ev_cnt[k] == '0) begin
            kind  = KIND_LONG;
            limit = timing_regs[CFG_LONG];
        end else if (ev_cnt[k] > timing_regs[CFG_FAST_AFTER]) begin
            kind  = KIND_FAST;
            limit = timing_regs[CFG_FAST];
        end else if (ev_cnt[k] > timing_regs[CFG_MED_AFTER]) begin
            kind  = KIND_MEDIUM;
            limit = timing_regs[CFG_MEDIUM];
        end else begin
            kind  = KIND_SLOW;
            limit = timing_regs[CFG_SLOW];
        end
        if (hold_tmr[k] >= limit) begin
            claim(k, kind);
            if (ev_cnt[k] != COUNT_MAX)
                ev_cnt[k]++;
            hold_tmr[k] = '0;
        end
    endfunction

    // a release gives a click only if the key was held and never fired
    function automatic void release_tick(input int k);
        if (held[k] && ev_cnt[k] == '0)
            claim(k, KIND_CLICK);
        drop_key(k);
    endfunction

    function automatic void keypad_tick(input logic [3:0] lv);
        logic pwr;
        logic up;
        logic dn;
        logic t;
        int   keep;
        tick_hit = 1'b0;
        pwr = !lv[0] || !lv[1];   // mode acts as a second power key
        up  = !lv[2];
        dn  = !lv[3];
        if (timing_regs[CFG_SWAP][0]) begin
            t  = up;
            up = dn;
            dn = t;
        end
        if (pwr) begin
            keep = up ? int'(KEY_PWRUP) : (dn ? int'(KEY_PWRDOWN) : int'(KEY_POWER));
            press_tick(keep);
            for (int k = 0; k < NUM_KEYS; k++)
                if (k != keep)
                    drop_key(k);
        end else begin
            release_tick(KEY_POWER);
            drop_key(KEY_PWRDOWN);
            drop_key(KEY_PWRUP);
            if (up && dn) begin
                press_tick(KEY_UPDOWN);
                drop_key(KEY_UP);
                drop_key(KEY_DOWN);
            end else if (up) begin
                press_tick(KEY_UP);
                drop_key(KEY_UPDOWN);
                drop_key(KEY_DOWN);
            end else begin
                release_tick(KEY_UP);
                drop_key(KEY_UPDOWN);
                if (dn) begin
                    press_tick(KEY_DOWN);
                end else begin
                    // everything up: ownership is released after this tick
                    release_tick(KEY_DOWN);
                    owner = OWNER_NONE;
                end
            end
        end
    endfunction

    function automatic void reset_model();
        timing_regs[CFG_SWAP]       = 16'd0;
        timing_regs[CFG_TICK]       = 16'd10;
        timing_regs[CFG_LONG]       = 16'd500;
        timing_regs[CFG_SLOW]       = 16'd200;
        timing_regs[CFG_MEDIUM]     = 16'd100;
        timing_regs[CFG_FAST]       = 16'd50;
        timing_regs[CFG_MED_AFTER]  = 16'd20;
        timing_regs[CFG_FAST_AFTER] = 16'd90;
        for (int k = 0; k < NUM_KEYS; k++)
            drop_key(k);
        owner    = OWNER_NONE;
        tick_hit = 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // hand one level word over, with an occasional gap in front of it
    task automatic put_word(input logic [3:0] lv);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {4'b0000, lv};
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        words_sent++;
    endtask

    task automatic play(input logic [3:0] lv);
        put_word(lv);
        keypad_tick(lv);
        if (tick_hit)
            events_due.push_back(tick_ev);
    endtask

    // stop sending, let every predicted event arrive and the pipeline empty
    task automatic settle();
        s_valid <= 1'b0;
        while (events_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write all registers back to back; only called while the block is idle
    task automatic load_regs();
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_we         <= 1'b1;
            cfg_addr       <= CFG_AW'(i);
            cfg_wdata      <= next_regs[i];
            timing_regs[i]  = next_regs[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [3:0] pick_press();
        if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 3))
                0: return LV_POWER;
                1: return LV_MODE;
                2: return LV_UP;
                default: return LV_DOWN;
            endcase
        end
        return 4'($urandom_range(0, 14));
    endfunction

    // mostly press, hold and release; some key changes mid-hold, noise and quick taps
    task automatic play_sequence(input int lo, input int hi);
        int          style;
        int          len;
        logic [3:0]  a;
        logic [3:0]  b;
        style = $urandom_range(0, 9);
        len   = $urandom_range(lo, hi);
        a     = pick_press();
        b     = pick_press();
        if (style <= 5) begin
            repeat (len) play(a);
            repeat ($urandom_range(1, 3)) play(LV_NONE);
        end else if (style <= 7) begin
            repeat (len / 2 + 1) play(a);
            repeat (len / 2 + 1) play(b);
            if ($urandom_range(0, 1) == 1)
                play(LV_NONE);
        end else if (style == 8) begin
            repeat ($urandom_range(1, 20)) play(4'($urandom_range(0, 15)));
        end else begin
            repeat ($urandom_range(1, 4)) begin
                play(pick_press());
                play(LV_NONE);
            end
        end
    endtask

    task automatic run_phase(input t_phase mode, input int target);
        int tk;
        int lo;
        int hi;
        int first;
        tk = $urandom_range(1, 255);
        lo = 1;
        hi = 25;
        case (mode)
            PH_TYPICAL: begin
                // short intervals in ticks so that every event kind turns up
                next_regs[CFG_SWAP]       = 16'($urandom_range(0, 1));
                next_regs[CFG_TICK]       = 16'(tk);
                next_regs[CFG_LONG]       = 16'($urandom_range(0, tk * 6));
                next_regs[CFG_SLOW]       = 16'($urandom_range(0, tk * 4));
                next_regs[CFG_MEDIUM]     = 16'($urandom_range(0, tk * 3));
                next_regs[CFG_FAST]       = 16'($urandom_range(0, tk * 2));
                next_regs[CFG_MED_AFTER]  = 16'($urandom_range(0, 5));
                next_regs[CFG_FAST_AFTER] = 16'($urandom_range(0, 10));
            end
            PH_WIDE: begin
                for (int i = 0; i < NUM_REGS; i++)
                    next_regs[i] = 16'($urandom_range(0, 65535));
                hi = 40;
            end
            PH_MAX: begin
                // largest tick and thresholds: a long click after 257 held increments
                for (int i = 0; i < NUM_REGS; i++)
                    next_regs[i] = 16'hFFFF;
                lo = 260;
                hi = 266;
            end
            PH_ZERO: begin
                // zero tick and thresholds: every held tick after the first of a press fires
                for (int i = 0; i < NUM_REGS; i++)
                    next_regs[i] = 16'h0000;
                hi = 8;
            end
            default: begin
                // timer runs past its top and sticks there before the long click
                next_regs[CFG_SWAP]       = 16'($urandom_range(0, 1));
                next_regs[CFG_TICK]       = 16'd254;
                next_regs[CFG_LONG]       = 16'hFFFF;
                next_regs[CFG_SLOW]       = 16'hFFFF;
                next_regs[CFG_MEDIUM]     = 16'($urandom_range(0, 65535));
                next_regs[CFG_FAST]       = 16'($urandom_range(0, 65535));
                next_regs[CFG_MED_AFTER]  = 16'($urandom_range(0, 3));
                next_regs[CFG_FAST_AFTER] = 16'($urandom_range(0, 3));
                lo = 262;
                hi = 268;
            end
        endcase
        load_regs();
        first = words_sent;
        while (words_sent - first < target)
            play_sequence(lo, hi);
        settle();
    endtask

    // ------------------------------------------------------------------
    // output side: compare each word taken against the oldest prediction,
    // then decide the ready level for the next edge
    // ------------------------------------------------------------------

    always @(posedge clk) begin : out_side
        t_event want;
        if (rst_n && m_valid && m_ready) begin
            if (events_due.size() == 0) begin
                $display("%0t: unexpected event word, expected none, got key %0d kind %0d",
                         $time, m_data[2:0], m_data[5:3]);
                fail_count++;
            end else begin
                want = events_due.pop_front();
                if (m_data[2:0] != want.key) begin
                    $display("%0t: event key expected %0d, got %0d",
                             $time, want.key, m_data[2:0]);
                    fail_count++;
                end
                if (m_data[5:3] != want.kind) begin
                    $display("%0t: event kind expected %0d, got %0d",
                             $time, want.kind, m_data[5:3]);
                    fail_count++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // run order
    // ------------------------------------------------------------------

    initial begin
        reset_model();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows at the reset timing
        for (int r = 0; r < 25; r++) begin
            for (int n = 1; n <= int'(SCRIPT[r].reps); n++) begin
                put_word(SCRIPT[r].lv);
                keypad_tick(SCRIPT[r].lv);
                if (SCRIPT[r].typed && n == int'(SCRIPT[r].reps)) begin
                    if (SCRIPT[r].hit)
                        events_due.push_back(t_event'{SCRIPT[r].key, SCRIPT[r].kind});
                end else if (tick_hit) begin
                    events_due.push_back(tick_ev);
                end
            end
        end
        settle();

        // random phases, each behind a full drain
        run_phase(PH_TYPICAL, 25);
        run_phase(PH_ZERO, 15);
        run_phase(PH_TYPICAL, 25);
        run_phase(PH_MAX, 200);
        run_phase(PH_TSAT, 200);
        run_phase(PH_WIDE, 15);
        run_phase(PH_TYPICAL, 25);

        // last stretch runs without gaps or stalls
        idle_on = 1'b0;
        run_phase(PH_TYPICAL, 25);

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
